[src/mbet_pkg.sv]
`timescale 1ns / 1ps

package mbet_pkg;

    localparam int FRAC_W      = 16;
    localparam int DATA_W      = 32;
    localparam int PROD_W      = 2 * DATA_W;
    localparam int COUNT_W     = 8;
    localparam int PALETTE_W   = 6;
    localparam int CFG_INDEX_W = 1;

    localparam logic [DATA_W-1:0]  BAILOUT_RESET = DATA_W'(16 << FRAC_W);
    localparam logic [COUNT_W-1:0] LIMIT_RESET   = COUNT_W'(64);

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_BAILOUT    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MUL_XX = 6'b000010,
        ST_MUL_YY = 6'b000100,
        ST_MUL_XY = 6'b001000,
        ST_UPDATE = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] op_a;
        logic signed [DATA_W-1:0] op_b;
    } mul_req_t;

endpackage

[src/mbet_mul.sv]
`timescale 1ns / 1ps

// Shared fixed-point multiplier: full signed product registered, the
// result is the product shifted right by FRAC_W, cut to DATA_W bits.
module mbet_mul
    import mbet_pkg::*;
(
    input  logic                     aclk,
    input  mul_req_t                 req,
    output logic signed [DATA_W-1:0] fx_result
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(req.op_a) * PROD_W'(req.op_b);
    end

    assign fx_result = prod_reg[FRAC_W+DATA_W-1:FRAC_W];

endmodule

[src/mandelbrot_escape_time_q16_top.sv]
`timescale 1ns / 1ps

// Mandelbrot escape-time unit, signed Q16.16.
// Input channel (s_valid/s_ready) takes one point (s_point_real, s_point_imag).
// Result channel (m_valid/m_ready) returns the iteration count and the count
// modulo 64 as a palette index, one result per point.
// Config channel (cfg_valid/cfg_ready, always ready) writes bailout_square
// (index 0) and iteration_limit (index 1); write only while idle.
// One multiplier is shared by the three products of each step, so each
// iteration steps through x*x, y*y, x*y, then escape test and update.
// m_valid rises as the unit leaves its done state; the default limit of 64
// caps the count at 64. One point is worked at a time: s_ready is high
// only when the unit is idle, so a new point is taken only once the last
// one has left its done state.
// The result sits in an output register, so the next point is taken while
// a result waits. If the receiver stalls and a second result is ready, the
// unit holds in its done state until the first one is taken.
// Reset (aresetn low, synchronous) restores bailout 16.0 and limit 64, and
// drops any point in flight and any pending result.
module mandelbrot_escape_time_q16_top
    import mbet_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [DATA_W-1:0] s_point_real,
    input  logic signed [DATA_W-1:0] s_point_imag,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [COUNT_W-1:0]       m_iteration_count,
    output logic [PALETTE_W-1:0]     m_palette_index,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_INDEX_W-1:0]   cfg_index,
    input  logic [DATA_W-1:0]        cfg_data
);

    state_t state_reg, state_next;

    logic [DATA_W-1:0]  bailout_reg;
    logic [COUNT_W-1:0] limit_reg;

    logic signed [DATA_W-1:0] cx_reg, cy_reg;
    logic signed [DATA_W-1:0] x_reg, y_reg;
    logic signed [DATA_W-1:0] xx_reg, yy_reg;
    logic [COUNT_W-1:0]       count_reg;

    logic                 m_valid_reg;
    logic [COUNT_W-1:0]   m_count_reg;
    logic [PALETTE_W-1:0] m_palette_reg;

    mul_req_t                 mul_req;
    logic signed [DATA_W-1:0] mul_result;
    logic [DATA_W-1:0]        square;
    logic                     finished;
    logic                     out_free;

    mbet_mul u_mul (
        .aclk      (aclk),
        .req       (mul_req),
        .fx_result (mul_result)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    assign m_valid           = m_valid_reg;
    assign m_iteration_count = m_count_reg;
    assign m_palette_index   = m_palette_reg;

    always_comb begin
        case (state_reg)
            ST_MUL_XX: begin
                mul_req.op_a = x_reg;
                mul_req.op_b = x_reg;
            end
            ST_MUL_YY: begin
                mul_req.op_a = y_reg;
                mul_req.op_b = y_reg;
            end
            default: begin
                mul_req.op_a = x_reg;
                mul_req.op_b = y_reg;
            end
        endcase
    end

    // squared magnitude of the current z; zero on the first step
    assign square   = DATA_W'(xx_reg + yy_reg);
    assign finished = (square > bailout_reg) || (count_reg >= limit_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_valid) state_next = ST_MUL_XX;
            ST_MUL_XX: state_next = ST_MUL_YY;
            ST_MUL_YY: state_next = ST_MUL_XY;
            ST_MUL_XY: state_next = ST_UPDATE;
            ST_UPDATE: state_next = finished ? ST_DONE : ST_MUL_XX;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            bailout_reg <= BAILOUT_RESET;
            limit_reg   <= LIMIT_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BAILOUT:    bailout_reg <= cfg_data;
                    REG_ITER_LIMIT: limit_reg   <= cfg_data[COUNT_W-1:0];
                    default:        ;
                endcase
            end
            if (state_reg == ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                cx_reg    <= s_point_real;
                cy_reg    <= s_point_imag;
                x_reg     <= '0;
                y_reg     <= '0;
                count_reg <= '0;
            end
            ST_MUL_YY: xx_reg <= mul_result;
            ST_MUL_XY: yy_reg <= mul_result;
            ST_UPDATE: begin
                if (!finished) begin
                    x_reg     <= xx_reg - yy_reg + cx_reg;
                    y_reg     <= {mul_result[DATA_W-2:0], 1'b0} + cy_reg;
                    count_reg <= count_reg + COUNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_count_reg   <= count_reg;
                    m_palette_reg <= count_reg[PALETTE_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // z starts from the origin for every point
    a_start_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (count_reg == '0 && x_reg == '0 && y_reg == '0))
        else $error("iteration state not cleared on new point");

    a_step_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE && !finished) |=>
            (count_reg == $past(count_reg) + COUNT_W'(1) && state_reg == ST_MUL_XX))
        else $error("iteration count did not advance by one");

    a_result_issued: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_valid_reg && state_reg == ST_IDLE))
        else $error("finished point did not produce a result");

    a_palette: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_palette_reg == m_count_reg[PALETTE_W-1:0]))
        else $error("palette index does not match count");

endmodule
